// ===== sv/tolerance_outer_merge_join_top_assert.svh =====
// assertion macros included by the join rtl
`ifndef TOLERANCE_OUTER_MERGE_JOIN_TOP_ASSERT_SVH
`define TOLERANCE_OUTER_MERGE_JOIN_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TOMJ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tomj check failed");

// next-cycle implication, checked outside reset
`define TOMJ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tomj check failed");

`endif

// ===== sv/tomj_pkg.sv =====
`timescale 1ns / 1ps

package tomj_pkg;

  localparam int MaxLen = 32;
  localparam int AddrW  = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int CntW   = $clog2(MaxLen + 1);
  localparam int KeyW   = 32;
  localparam int TolW   = 31;
  localparam int IdxW   = 8;
  localparam int DiffW  = KeyW + 1;

  localparam logic [DiffW-1:0] DIFF_INF = '1;

  localparam logic [1:0] ACT_LOAD_X = 2'd0;
  localparam logic [1:0] ACT_LOAD_Y = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;

  typedef struct packed {
    logic [1:0]             action;
    logic signed [KeyW-1:0] key;
    logic [TolW-1:0]        tolerance;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0] x_index;
    logic [IdxW-1:0] y_index;
    logic            last;
  } out_t;

  typedef struct packed {
    logic             x_we;
    logic             y_we;
    logic [AddrW-1:0] addr;
    logic [KeyW-1:0]  key;
    logic [TolW-1:0]  tol;
  } mem_wr_t;

  typedef struct packed {
    logic [AddrW-1:0] x_addr;
    logic [AddrW-1:0] y_addr;
  } mem_rd_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_STEP   = 10'b00_0000_0010,
    ST_RD_CUR = 10'b00_0000_0100,
    ST_RD_NXT = 10'b00_0000_1000,
    ST_D0     = 10'b00_0001_0000,
    ST_D1     = 10'b00_0010_0000,
    ST_D2     = 10'b00_0100_0000,
    ST_D3     = 10'b00_1000_0000,
    ST_DECIDE = 10'b01_0000_0000,
    ST_PUT    = 10'b10_0000_0000
  } state_t;

endpackage

// ===== sv/tomj_ram.sv =====
`timescale 1ns / 1ps

module tomj_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tomj_absdiff.sv =====
`timescale 1ns / 1ps

module tomj_absdiff (
  input  logic signed [tomj_pkg::KeyW-1:0] a,
  input  logic signed [tomj_pkg::KeyW-1:0] b,
  output logic [tomj_pkg::DiffW-1:0]       diff,
  output logic                             a_lt_b
);

  logic signed [tomj_pkg::KeyW:0] sub;
  logic signed [tomj_pkg::KeyW:0] mag;

  always_comb begin
    sub    = {a[tomj_pkg::KeyW-1], a} - {b[tomj_pkg::KeyW-1], b};
    a_lt_b = sub[tomj_pkg::KeyW];
    mag    = a_lt_b ? -sub : sub;
    diff   = {1'b0, mag[tomj_pkg::KeyW-1:0]};
  end

endmodule

// ===== sv/tomj_join.sv =====
`timescale 1ns / 1ps

module tomj_join (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  tomj_pkg::in_t               item,
  input  logic                        cfg_we,
  input  logic [tomj_pkg::IdxW-1:0]   cfg_wdata,
  output logic                        result_valid,
  input  logic                        result_stall,
  output tomj_pkg::out_t              result,
  output tomj_pkg::mem_wr_t           wr,
  output tomj_pkg::mem_rd_t           rd,
  input  logic [tomj_pkg::KeyW-1:0]   x_key_q,
  input  logic [tomj_pkg::TolW-1:0]   x_tol_q,
  input  logic [tomj_pkg::KeyW-1:0]   y_key_q
);

  `include "tolerance_outer_merge_join_top_assert.svh"

  tomj_pkg::state_t state, state_next;

  logic [tomj_pkg::CntW-1:0]  x_count, y_count, ix, iy;
  logic [tomj_pkg::CntW-1:0]  ix_inc, iy_inc, ix_step, iy_step;
  logic [tomj_pkg::IdxW-1:0]  nm;
  logic signed [tomj_pkg::KeyW-1:0] xk, yk, xn, yn;
  logic signed [tomj_pkg::KeyW-1:0] op_a, op_b;
  logic [tomj_pkg::TolW-1:0]  tol;
  logic [tomj_pkg::DiffW-1:0] d, dx, dy, dxy, ad_diff;
  logic ad_lt, x_lt_y, dx_lt_d, dy_lt_d, dx_lt_dy;
  logic take_x, take_y, hx, hy;
  logic accept, push, run_last, in_tol, nearer;
  logic x_room, y_room;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != tomj_pkg::ST_IDLE);
  assign push       = (state == tomj_pkg::ST_PUT) && (!result_valid || !result_stall);

  assign ix_inc  = ix + tomj_pkg::CntW'(1);
  assign iy_inc  = iy + tomj_pkg::CntW'(1);
  assign hx      = ix_inc < x_count;
  assign hy      = iy_inc < y_count;
  assign ix_step = ix + tomj_pkg::CntW'(take_x);
  assign iy_step = iy + tomj_pkg::CntW'(take_y);
  assign run_last = (ix_step >= x_count) && (iy_step >= y_count);

  assign x_room = x_count < tomj_pkg::CntW'(tomj_pkg::MaxLen);
  assign y_room = y_count < tomj_pkg::CntW'(tomj_pkg::MaxLen);

  // store writes on loads
  always_comb begin
    wr.x_we = accept && (item.action == tomj_pkg::ACT_LOAD_X) && x_room;
    wr.y_we = accept && (item.action == tomj_pkg::ACT_LOAD_Y) && y_room;
    wr.addr = (item.action == tomj_pkg::ACT_LOAD_X) ? x_count[tomj_pkg::AddrW-1:0]
                                                    : y_count[tomj_pkg::AddrW-1:0];
    wr.key  = item.key;
    wr.tol  = item.tolerance;
  end

  // current entries first, then the look-ahead neighbours
  always_comb begin
    if (state == tomj_pkg::ST_RD_CUR) begin
      rd.x_addr = ix[tomj_pkg::AddrW-1:0];
      rd.y_addr = iy[tomj_pkg::AddrW-1:0];
    end else begin
      rd.x_addr = ix_inc[tomj_pkg::AddrW-1:0];
      rd.y_addr = iy_inc[tomj_pkg::AddrW-1:0];
    end
  end

  // operand select for the shared difference unit
  always_comb begin
    case (state)
      tomj_pkg::ST_D0: begin
        op_a = xk;
        op_b = yk;
      end
      tomj_pkg::ST_D1: begin
        op_a = xn;
        op_b = yk;
      end
      tomj_pkg::ST_D2: begin
        op_a = xk;
        op_b = yn;
      end
      default: begin
        op_a = xn;
        op_b = yn;
      end
    endcase
  end

  tomj_absdiff u_absdiff (
    .a      (op_a),
    .b      (op_b),
    .diff   (ad_diff),
    .a_lt_b (ad_lt)
  );

  assign in_tol = d <= {{(tomj_pkg::DiffW-tomj_pkg::TolW){1'b0}}, tol};
  assign nearer = (dx_lt_d && (dx < dxy)) || (dy_lt_d && (dy < dxy));

  always_comb begin
    state_next = state;
    unique case (state)
      tomj_pkg::ST_IDLE: begin
        if (accept && (item.action == tomj_pkg::ACT_RUN) &&
            ((x_count != '0) || (y_count != '0))) begin
          state_next = tomj_pkg::ST_STEP;
        end
      end
      tomj_pkg::ST_STEP: begin
        if ((ix >= x_count) || (iy >= y_count)) begin
          state_next = tomj_pkg::ST_PUT;
        end else begin
          state_next = tomj_pkg::ST_RD_CUR;
        end
      end
      tomj_pkg::ST_RD_CUR: state_next = tomj_pkg::ST_RD_NXT;
      tomj_pkg::ST_RD_NXT: state_next = tomj_pkg::ST_D0;
      tomj_pkg::ST_D0:     state_next = tomj_pkg::ST_D1;
      tomj_pkg::ST_D1:     state_next = tomj_pkg::ST_D2;
      tomj_pkg::ST_D2:     state_next = tomj_pkg::ST_D3;
      tomj_pkg::ST_D3:     state_next = tomj_pkg::ST_DECIDE;
      tomj_pkg::ST_DECIDE: state_next = tomj_pkg::ST_PUT;
      tomj_pkg::ST_PUT: begin
        if (push) begin
          state_next = run_last ? tomj_pkg::ST_IDLE : tomj_pkg::ST_STEP;
        end
      end
      default: state_next = tomj_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tomj_pkg::ST_IDLE;
      x_count      <= '0;
      y_count      <= '0;
      ix           <= '0;
      iy           <= '0;
      nm           <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= push || (result_valid && result_stall);
      if (cfg_we) begin
        nm <= cfg_wdata;
      end
      if (wr.x_we) begin
        x_count <= x_count + tomj_pkg::CntW'(1);
      end
      if (wr.y_we) begin
        y_count <= y_count + tomj_pkg::CntW'(1);
      end
      if (state == tomj_pkg::ST_IDLE) begin
        ix <= '0;
        iy <= '0;
      end
      if (push) begin
        if (run_last) begin
          ix      <= '0;
          iy      <= '0;
          x_count <= '0;
          y_count <= '0;
        end else begin
          ix <= ix_step;
          iy <= iy_step;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      tomj_pkg::ST_STEP: begin
        take_x <= (iy >= y_count);
        take_y <= (ix >= x_count);
      end
      tomj_pkg::ST_RD_NXT: begin
        xk  <= signed'(x_key_q);
        yk  <= signed'(y_key_q);
        tol <= x_tol_q;
      end
      tomj_pkg::ST_D0: begin
        xn     <= signed'(x_key_q);
        yn     <= signed'(y_key_q);
        d      <= ad_diff;
        x_lt_y <= ad_lt;
      end
      tomj_pkg::ST_D1: begin
        dx <= hx ? ad_diff : tomj_pkg::DIFF_INF;
      end
      tomj_pkg::ST_D2: begin
        dy      <= hy ? ad_diff : tomj_pkg::DIFF_INF;
        dx_lt_d <= dx < d;
      end
      tomj_pkg::ST_D3: begin
        dxy      <= (hx && hy) ? ad_diff : tomj_pkg::DIFF_INF;
        dy_lt_d  <= dy < d;
        dx_lt_dy <= dx < dy;
      end
      tomj_pkg::ST_DECIDE: begin
        if (in_tol) begin
          if (nearer) begin
            take_x <= dx_lt_dy;
            take_y <= !dx_lt_dy;
          end else begin
            take_x <= 1'b1;
            take_y <= 1'b1;
          end
        end else begin
          take_x <= x_lt_y;
          take_y <= !x_lt_y;
        end
      end
      default: begin
      end
    endcase
    if (push) begin
      result.x_index <= take_x ? tomj_pkg::IdxW'(ix_inc) : nm;
      result.y_index <= take_y ? tomj_pkg::IdxW'(iy_inc) : nm;
      result.last    <= run_last;
    end
  end

  `TOMJ_ASSERT_NOW(a_ix_in_range, 1'b1, (ix <= x_count) && (iy <= y_count))
  `TOMJ_ASSERT_NOW(a_step_has_work, state == tomj_pkg::ST_STEP, (ix < x_count) || (iy < y_count))
  `TOMJ_ASSERT_NOW(a_put_advances, state == tomj_pkg::ST_PUT, take_x || take_y)
  `TOMJ_ASSERT_NEXT(a_last_clears, push && run_last, (x_count == '0) && (y_count == '0))

endmodule

// ===== sv/tolerance_outer_merge_join_top.sv =====
`timescale 1ns / 1ps

// Sorted outer merge join with a per-key tolerance. Beats with action 0 or 1
// append a key (and for x a tolerance) to list x or y, one beat per cycle;
// loads into a full list of 32 are dropped. A run beat walks both lists and
// sends one result beat per outer-join pair, with 1-based indices, the
// no-match code for a missing side, and last on the final pair; afterwards
// both lists are empty. A run of two empty lists sends nothing. During a run
// the input stalls. Pairs are made one at a time; one where both sides remain
// passes read, difference and decide states, and each waits while the result
// side stalls: the key stores have one read port each and every key
// difference goes through one shared subtractor, four differences per such
// pair. The no-match code may be written whenever no run is in progress.
module tolerance_outer_merge_join_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  tomj_pkg::in_t             item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output tomj_pkg::out_t            result,
  input  logic                      cfg_we,
  input  logic [tomj_pkg::IdxW-1:0] cfg_wdata
);

  tomj_pkg::mem_wr_t wr;
  tomj_pkg::mem_rd_t rd;
  logic [tomj_pkg::KeyW-1:0] x_key_q, y_key_q;
  logic [tomj_pkg::TolW-1:0] x_tol_q;

  tomj_ram #(.Width(tomj_pkg::KeyW), .Depth(tomj_pkg::MaxLen)) u_x_keys (
    .clk   (clk),
    .we    (wr.x_we),
    .waddr (wr.addr),
    .wdata (wr.key),
    .raddr (rd.x_addr),
    .rdata (x_key_q)
  );

  tomj_ram #(.Width(tomj_pkg::TolW), .Depth(tomj_pkg::MaxLen)) u_x_tols (
    .clk   (clk),
    .we    (wr.x_we),
    .waddr (wr.addr),
    .wdata (wr.tol),
    .raddr (rd.x_addr),
    .rdata (x_tol_q)
  );

  tomj_ram #(.Width(tomj_pkg::KeyW), .Depth(tomj_pkg::MaxLen)) u_y_keys (
    .clk   (clk),
    .we    (wr.y_we),
    .waddr (wr.addr),
    .wdata (wr.key),
    .raddr (rd.y_addr),
    .rdata (y_key_q)
  );

  tomj_join u_join (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr           (wr),
    .rd           (rd),
    .x_key_q      (x_key_q),
    .x_tol_q      (x_tol_q),
    .y_key_q      (y_key_q)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int SettleCycles = 40;
  localparam int OneQ = 1 << 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  tomj_pkg::in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  tomj_pkg::out_t result;
  logic cfg_we = 1'b0;
  logic [tomj_pkg::IdxW-1:0] cfg_wdata = '0;

  // join predictor state
  logic signed [tomj_pkg::KeyW-1:0] x_key_list [tomj_pkg::MaxLen];
  logic [tomj_pkg::TolW-1:0] x_tol_list [tomj_pkg::MaxLen];
  logic signed [tomj_pkg::KeyW-1:0] y_key_list [tomj_pkg::MaxLen];
  int x_len = 0;
  int y_len = 0;
  logic [tomj_pkg::IdxW-1:0] miss_code = '0;

  tomj_pkg::out_t pending_pairs[$];
  bit failed = 1'b0;
  bit idle_en = 1'b1;
  bit send_gaps = 1'b1;

  tolerance_outer_merge_join_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [tomj_pkg::DiffW-1:0] key_gap(
      logic signed [tomj_pkg::KeyW-1:0] a, logic signed [tomj_pkg::KeyW-1:0] b);
    longint la;
    longint lb;
    la = a;
    lb = b;
    return (la >= lb) ? tomj_pkg::DiffW'(la - lb) : tomj_pkg::DiffW'(lb - la);
  endfunction

  function automatic tomj_pkg::in_t mk(logic [1:0] act, logic signed [tomj_pkg::KeyW-1:0] k,
                                       logic [tomj_pkg::TolW-1:0] t);
    tomj_pkg::in_t b;
    b.action = act;
    b.key = k;
    b.tolerance = t;
    return b;
  endfunction

  // updates the lists and queues every pair a run beat produces
  function automatic void predict_join_pairs(tomj_pkg::in_t b);
    int ix;
    int iy;
    int first;
    bit step_x;
    bit step_y;
    tomj_pkg::out_t p;
    logic [tomj_pkg::DiffW-1:0] d, dx, dy, dxy;
    case (b.action)
      tomj_pkg::ACT_LOAD_X: begin
        if (x_len < tomj_pkg::MaxLen) begin
          x_key_list[x_len] = b.key;
          x_tol_list[x_len] = b.tolerance;
          x_len++;
        end
      end
      tomj_pkg::ACT_LOAD_Y: begin
        if (y_len < tomj_pkg::MaxLen) begin
          y_key_list[y_len] = b.key;
          y_len++;
        end
      end
      tomj_pkg::ACT_RUN: begin
        ix = 0;
        iy = 0;
        first = pending_pairs.size();
        while (ix < x_len || iy < y_len) begin
          step_x = 1'b0;
          step_y = 1'b0;
          if (ix >= x_len) begin
            step_y = 1'b1;
          end else if (iy >= y_len) begin
            step_x = 1'b1;
          end else begin
            d = key_gap(x_key_list[ix], y_key_list[iy]);
            if (d <= tomj_pkg::DiffW'(x_tol_list[ix])) begin
              dx = (ix + 1 < x_len) ?
                   key_gap(x_key_list[ix + 1], y_key_list[iy]) : tomj_pkg::DIFF_INF;
              dy = (iy + 1 < y_len) ?
                   key_gap(x_key_list[ix], y_key_list[iy + 1]) : tomj_pkg::DIFF_INF;
              dxy = (ix + 1 < x_len && iy + 1 < y_len) ?
                    key_gap(x_key_list[ix + 1], y_key_list[iy + 1]) : tomj_pkg::DIFF_INF;
              if ((dx < d && dx < dxy) || (dy < d && dy < dxy)) begin
                if (dx < dy) step_x = 1'b1;
                else step_y = 1'b1;
              end else begin
                step_x = 1'b1;
                step_y = 1'b1;
              end
            end else if (x_key_list[ix] < y_key_list[iy]) begin
              step_x = 1'b1;
            end else begin
              step_y = 1'b1;
            end
          end
          if (step_x) ix++;
          if (step_y) iy++;
          p.x_index = step_x ? tomj_pkg::IdxW'(ix) : miss_code;
          p.y_index = step_y ? tomj_pkg::IdxW'(iy) : miss_code;
          p.last = 1'b0;
          pending_pairs.push_back(p);
        end
        if (pending_pairs.size() > first) pending_pairs[$].last = 1'b1;
        x_len = 0;
        y_len = 0;
      end
      default: ;
    endcase
  endfunction

  // result beat checker
  always @(posedge clk) begin
    tomj_pkg::out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_pairs.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected beat x=%0d y=%0d last=%0b", $time,
                 result.x_index, result.y_index, result.last);
      end else begin
        want = pending_pairs.pop_front();
        if (result.x_index !== want.x_index || result.y_index !== want.y_index ||
            result.last !== want.last) begin
          failed = 1'b1;
          $display("%0t: mismatch expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   $time, want.x_index, want.y_index, want.last,
                   result.x_index, result.y_index, result.last);
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        result_stall <= 1'b0;
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_beat(input tomj_pkg::in_t b);
    if (idle_en && send_gaps && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    item <= b;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    predict_join_pairs(b);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_miss_code(input logic [tomj_pkg::IdxW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    miss_code = v;
  endtask

  task automatic test_directed_cases();
    send_beat(mk(tomj_pkg::ACT_RUN, '0, '0));
    send_beat(mk(ACT_NONE, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    send_beat(mk(tomj_pkg::ACT_LOAD_X, 32'sh8000_0000, '0));
    send_beat(mk(tomj_pkg::ACT_LOAD_X, '0, 31'h7FFF_FFFF));
    send_beat(mk(tomj_pkg::ACT_LOAD_Y, 32'sh7FFF_FFFF, '0));
    send_beat(mk(tomj_pkg::ACT_RUN, '0, '0));
    wait_idle();
    set_miss_code(8'hFF);
    // nearer x neighbour makes x advance alone
    send_beat(mk(tomj_pkg::ACT_LOAD_X, '0, tomj_pkg::TolW'(10 * OneQ)));
    send_beat(mk(tomj_pkg::ACT_LOAD_X, 5 * OneQ, tomj_pkg::TolW'(10 * OneQ)));
    send_beat(mk(tomj_pkg::ACT_LOAD_Y, 4 * OneQ, '0));
    send_beat(mk(tomj_pkg::ACT_RUN, '0, '0));
    // nearer y neighbour makes y advance alone
    send_beat(mk(tomj_pkg::ACT_LOAD_X, 4 * OneQ, tomj_pkg::TolW'(10 * OneQ)));
    send_beat(mk(tomj_pkg::ACT_LOAD_Y, '0, '0));
    send_beat(mk(tomj_pkg::ACT_LOAD_Y, 3 * OneQ, '0));
    send_beat(mk(tomj_pkg::ACT_RUN, '0, '0));
    // y only, then unsorted x only
    send_beat(mk(tomj_pkg::ACT_LOAD_Y, OneQ, '0));
    send_beat(mk(tomj_pkg::ACT_LOAD_Y, 2 * OneQ, '0));
    send_beat(mk(tomj_pkg::ACT_RUN, '0, '0));
    send_beat(mk(tomj_pkg::ACT_LOAD_X, 3 * OneQ, '0));
    send_beat(mk(tomj_pkg::ACT_LOAD_X, OneQ, '0));
    send_beat(mk(tomj_pkg::ACT_RUN, '0, '0));
    wait_idle();
    // no-match code collides with a real index
    set_miss_code(8'h01);
    send_beat(mk(tomj_pkg::ACT_LOAD_X, 100, '0));
    send_beat(mk(tomj_pkg::ACT_LOAD_Y, 200, '0));
    send_beat(mk(tomj_pkg::ACT_LOAD_X, 300, '0));
    send_beat(mk(tomj_pkg::ACT_LOAD_Y, 300, '0));
    send_beat(mk(tomj_pkg::ACT_RUN, '0, '0));
  endtask

  task automatic test_list_overflow();
    for (int i = 0; i < tomj_pkg::MaxLen + 2; i++) begin
      send_beat(mk(tomj_pkg::ACT_LOAD_X, i * OneQ, tomj_pkg::TolW'(OneQ / 2)));
      if (i <= tomj_pkg::MaxLen) begin
        send_beat(mk(tomj_pkg::ACT_LOAD_Y, i * OneQ + 3 * OneQ / 4, '0));
      end
    end
    send_beat(mk(tomj_pkg::ACT_RUN, '0, '0));
  endtask

  task automatic test_random_joins(input int n_items);
    int sent;
    int nx;
    int ny;
    int cx;
    int cy;
    int step_max;
    bit noisy;
    logic signed [tomj_pkg::KeyW-1:0] kx;
    logic signed [tomj_pkg::KeyW-1:0] ky;
    logic [tomj_pkg::TolW-1:0] tol;
    tomj_pkg::in_t b;
    sent = 0;
    while (sent < n_items) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      noisy = ($urandom_range(0, 7) == 0);
      nx = ($urandom_range(0, 15) == 0) ? $urandom_range(9, tomj_pkg::MaxLen + 2)
                                        : $urandom_range(0, 8);
      ny = ($urandom_range(0, 15) == 0) ? $urandom_range(9, tomj_pkg::MaxLen + 2)
                                        : $urandom_range(0, 8);
      step_max = $urandom_range(0, 1) ? OneQ : 4 * OneQ;
      kx = ($urandom_range(0, 7) == 0) ? 32'sh8000_0000 : $signed($urandom) >>> 2;
      ky = kx + $urandom_range(0, step_max);
      cx = 0;
      cy = 0;
      while (cx < nx || cy < ny) begin
        if (noisy && $urandom_range(0, 5) == 0) begin
          send_beat(mk(ACT_NONE, $urandom, tomj_pkg::TolW'($urandom)));
        end
        tol = ($urandom_range(0, 7) == 0) ? tomj_pkg::TolW'($urandom)
                                          : tomj_pkg::TolW'($urandom_range(0, step_max));
        if (cy >= ny || (cx < nx && $urandom_range(0, 1) == 1)) begin
          b = mk(tomj_pkg::ACT_LOAD_X, noisy ? $signed($urandom) : kx, tol);
          kx = kx + $urandom_range(0, step_max);
          cx++;
        end else begin
          b = mk(tomj_pkg::ACT_LOAD_Y, noisy ? $signed($urandom) : ky, tol);
          ky = ky + $urandom_range(0, step_max);
          cy++;
        end
        send_beat(b);
        sent++;
      end
      send_beat(mk(tomj_pkg::ACT_RUN, $urandom, tomj_pkg::TolW'($urandom)));
      sent++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_cases();
    test_list_overflow();
    wait_idle();
    set_miss_code(tomj_pkg::IdxW'($urandom_range(2, 254)));
    test_random_joins(80);
    wait_idle();
    set_miss_code(8'h00);
    test_random_joins(70);
    idle_en = 1'b0;
    wait_idle();
    set_miss_code(8'hFF);
    test_random_joins(80);
    wait_idle();
    if (!failed && pending_pairs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
